FILE: src/rob_pkg.sv
// Shared types and constants for the reorder buffer with branch recovery.
`timescale 1ns / 1ps

package rob_pkg;

    // Default number of entries in the buffer
    localparam int ROB_DEPTH_DEFAULT = 32;

    // Fixed field widths
    localparam int DEST_W  = 5;
    localparam int ID_W    = 5;
    localparam int TID_W   = 8;
    localparam int WORD_W  = 32;
    localparam int KIND_W  = 2;

    // Request kinds; the fourth code is unused and changes nothing
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CYCLE = 2'd2
    } kind_t;

    // One input request
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DEST_W-1:0] dest_reg;
        logic              branch_flag;
        logic              taken_flag;
        logic              predicted_flag;
        logic [WORD_W-1:0] predicted_target;
        logic [TID_W-1:0]  target_id;
        logic [WORD_W-1:0] result_value;
    } item_t;

    // One result
    typedef struct packed {
        logic              alloc_ok;
        logic [ID_W-1:0]   alloc_id;
        logic              write_error;
        logic              redirect;
        logic [WORD_W-1:0] redirect_pc;
        logic              commit_valid;
        logic [ID_W-1:0]   commit_id;
        logic [WORD_W-1:0] commit_value;
        logic [DEST_W-1:0] commit_dest;
        logic              reg_write;
        logic              full_flag;
        logic              empty_flag;
    } result_t;

    // Fields fixed at allocation: {pred_target, prediction, taken, branch, dest}
    localparam int STATIC_W = WORD_W + 3 + DEST_W;
    // Fields written at allocation and by write result: {done, value}
    localparam int DYN_W    = WORD_W + 1;

endpackage

FILE: src/rob_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port (read-first).
`timescale 1ns / 1ps

module rob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read; a same-address read returns old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/rob_engine.sv
// Pointer state, entry storage and per-request decision logic of the reorder buffer.
`timescale 1ns / 1ps

module rob_engine #(
    parameter int ROB_DEPTH = rob_pkg::ROB_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  rob_pkg::item_t   item,
    output rob_pkg::result_t result
);

    localparam int IDX_W = $clog2(ROB_DEPTH);
    localparam int OCC_W = $clog2(ROB_DEPTH + 1);
    localparam int CMP_W = (OCC_W > rob_pkg::TID_W) ? OCC_W : rob_pkg::TID_W;

    // pointers and fill level
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0] occ_reg, occ_next;

    // storage ports
    logic                         sta_wr_en;
    logic [rob_pkg::STATIC_W-1:0] sta_wr_data, sta_rd_data;
    logic                         dyn_wr_en;
    logic [IDX_W-1:0]             dyn_wr_addr;
    logic [rob_pkg::DYN_W-1:0]    dyn_wr_data, dyn_rd_data;

    // bypass of a write that hit the entry being read
    logic                         sta_byp_reg, sta_byp_next;
    logic [rob_pkg::STATIC_W-1:0] sta_byp_data_reg;
    logic                         dyn_byp_reg, dyn_byp_next;
    logic [rob_pkg::DYN_W-1:0]    dyn_byp_data_reg;

    // head entry view
    logic [rob_pkg::STATIC_W-1:0] sta_head;
    logic [rob_pkg::DYN_W-1:0]    dyn_head;
    logic [rob_pkg::DEST_W-1:0]   head_dest;
    logic                         head_branch;
    logic                         head_taken;
    logic                         head_pred;
    logic [rob_pkg::WORD_W-1:0]   head_ptarget;
    logic                         head_done;
    logic [rob_pkg::WORD_W-1:0]   head_value;

    // write result addressing
    logic [CMP_W-1:0] id_ext;
    logic [IDX_W-1:0] id_idx;
    logic [OCC_W-1:0] id_off;
    logic             id_busy;
    logic             is_full;
    logic             do_alloc;
    logic             do_write;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        r = (p == IDX_W'(ROB_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    rob_ram #(
        .WIDTH (rob_pkg::STATIC_W),
        .DEPTH (ROB_DEPTH)
    ) u_static_ram (
        .clk     (clk),
        .wr_en   (sta_wr_en),
        .wr_addr (tail_reg),
        .wr_data (sta_wr_data),
        .rd_addr (head_next),
        .rd_data (sta_rd_data)
    );

    rob_ram #(
        .WIDTH (rob_pkg::DYN_W),
        .DEPTH (ROB_DEPTH)
    ) u_dyn_ram (
        .clk     (clk),
        .wr_en   (dyn_wr_en),
        .wr_addr (dyn_wr_addr),
        .wr_data (dyn_wr_data),
        .rd_addr (head_next),
        .rd_data (dyn_rd_data)
    );

    // head entry with bypass
    always_comb
    begin
        sta_head     = sta_byp_reg ? sta_byp_data_reg : sta_rd_data;
        dyn_head     = dyn_byp_reg ? dyn_byp_data_reg : dyn_rd_data;
        head_dest    = sta_head[rob_pkg::DEST_W-1:0];
        head_branch  = sta_head[rob_pkg::DEST_W];
        head_taken   = sta_head[rob_pkg::DEST_W+1];
        head_pred    = sta_head[rob_pkg::DEST_W+2];
        head_ptarget = sta_head[rob_pkg::STATIC_W-1:rob_pkg::DEST_W+3];
        head_value   = dyn_head[rob_pkg::WORD_W-1:0];
        head_done    = dyn_head[rob_pkg::WORD_W];
    end

    // busy check: an id is busy when it lies in the occupied window from head
    always_comb
    begin
        id_ext = CMP_W'(item.target_id);
        id_idx = id_ext[IDX_W-1:0];
        if (id_idx >= head_reg)
        begin
            id_off = OCC_W'(id_idx) - OCC_W'(head_reg);
        end
        else
        begin
            id_off = OCC_W'(ROB_DEPTH) - OCC_W'(head_reg) + OCC_W'(id_idx);
        end
        id_busy = (id_ext < CMP_W'(ROB_DEPTH)) && (id_off < occ_reg);
    end

    // request decode and result
    always_comb
    begin
        result    = '0;
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        is_full   = (occ_reg == OCC_W'(ROB_DEPTH));
        do_alloc  = 1'b0;
        do_write  = 1'b0;

        case (rob_pkg::kind_t'(item.kind))
            rob_pkg::KIND_ALLOC:
            begin
                if (!is_full)
                begin
                    do_alloc        = 1'b1;
                    result.alloc_ok = 1'b1;
                    result.alloc_id = rob_pkg::ID_W'(tail_reg);
                    tail_next       = ptr_inc(tail_reg);
                    occ_next        = occ_reg + 1'b1;
                end
            end
            rob_pkg::KIND_WRITE:
            begin
                if (id_busy)
                begin
                    do_write = 1'b1;
                end
                else
                begin
                    result.write_error = 1'b1;
                end
            end
            rob_pkg::KIND_CYCLE:
            begin
                if ((occ_reg != '0) && head_branch && head_done && (head_taken != head_pred))
                begin
                    // mispredicted branch at head: flush everything
                    result.redirect    = 1'b1;
                    result.redirect_pc = head_taken ? head_value : head_ptarget;
                    head_next          = tail_reg;
                    occ_next           = '0;
                end
                else if ((occ_reg != '0) && head_done)
                begin
                    result.commit_valid = 1'b1;
                    result.commit_id    = rob_pkg::ID_W'(head_reg);
                    result.commit_value = head_value;
                    result.commit_dest  = head_dest;
                    result.reg_write    = (head_dest != '0);
                    head_next           = ptr_inc(head_reg);
                    occ_next            = occ_reg - 1'b1;
                end
            end
            default:
            begin
                // unused kind: flags only
            end
        endcase

        result.full_flag  = (occ_next == OCC_W'(ROB_DEPTH));
        result.empty_flag = (occ_next == '0);

        // hold state unless the request is being processed
        if (!fire)
        begin
            head_next = head_reg;
            tail_next = tail_reg;
            occ_next  = occ_reg;
        end
    end

    // storage writes
    always_comb
    begin
        sta_wr_en   = fire && do_alloc;
        sta_wr_data = {item.predicted_target, item.predicted_flag, item.taken_flag,
                       item.branch_flag, item.dest_reg};
        dyn_wr_en   = fire && (do_alloc || do_write);
        dyn_wr_addr = do_alloc ? tail_reg : id_idx;
        dyn_wr_data = do_alloc ? '0 : {1'b1, item.result_value};
        sta_byp_next = sta_wr_en && (tail_reg == head_next);
        dyn_byp_next = dyn_wr_en && (dyn_wr_addr == head_next);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            sta_byp_reg <= 1'b0;
            dyn_byp_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            sta_byp_reg <= sta_byp_next;
            dyn_byp_reg <= dyn_byp_next;
        end
    end

    // bypass payload
    always_ff @(posedge clk)
    begin
        sta_byp_data_reg <= sta_wr_data;
        dyn_byp_data_reg <= dyn_wr_data;
    end

    // fill level never exceeds the depth
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(ROB_DEPTH))
        else $error("occupancy above depth");

    // differing pointers mean a partly filled buffer
    a_ptr_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != tail_reg) |-> (occ_reg != '0 && occ_reg != OCC_W'(ROB_DEPTH)))
        else $error("pointers disagree with occupancy");

    // a flush and a retire never happen together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(result.redirect && result.commit_valid))
        else $error("redirect and commit in one request");

    // after a flush the buffer is empty
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.redirect) |=> (occ_reg == '0 && head_reg == tail_reg))
        else $error("flush left entries behind");

endmodule

FILE: src/reorder_buffer_with_branch_recovery_top.sv
// Top level of the reorder buffer: stream ports, request register and result register.
`timescale 1ns / 1ps

// Reorder buffer with branch recovery. Each request (allocate, write result,
// commit cycle) gives exactly one result. One request is taken per clock
// while the output is drained; a request sits in the input register, where
// its work is done against the head/tail pointers and the entry storage, and
// its result is then registered and shown from the output register, so
// throughput is one request per cycle while the output is drained.
// Entry fields live in two RAMs with registered reads; the head entry is
// prefetched every cycle from the next head pointer, with a one-entry bypass
// for a write that lands on it. Busy state follows from the pointers: a flush
// only moves head to tail, and no clearing pass is needed after reset.
module reorder_buffer_with_branch_recovery_top #(
    parameter int ROB_DEPTH = rob_pkg::ROB_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // dest_reg[4:0], branch_flag[5], taken_flag[6], predicted_flag[7],
    // predicted_target[39:8], target_id[47:40], result_value[79:48]
    input  logic [79:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // alloc_ok[0], alloc_id[5:1], write_error[6], redirect[7], redirect_pc[39:8],
    // commit_valid[40], commit_id[45:41], commit_value[77:46], commit_dest[82:78],
    // reg_write[83], full_flag[84], empty_flag[85], zero[87:86]
    output logic [87:0] m_tdata
);

    logic             in_valid_reg;
    rob_pkg::item_t   in_item_reg;
    rob_pkg::item_t   in_item;
    logic             out_valid_reg;
    rob_pkg::result_t out_res_reg;
    rob_pkg::result_t res;
    logic             fire;

    // handshake
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;

    // unpack request
    always_comb
    begin
        in_item.kind             = s_tuser;
        in_item.dest_reg         = s_tdata[4:0];
        in_item.branch_flag      = s_tdata[5];
        in_item.taken_flag       = s_tdata[6];
        in_item.predicted_flag   = s_tdata[7];
        in_item.predicted_target = s_tdata[39:8];
        in_item.target_id        = s_tdata[47:40];
        in_item.result_value     = s_tdata[79:48];
    end

    rob_engine #(
        .ROB_DEPTH (ROB_DEPTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (res)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    // pack result
    assign m_tdata = {2'b00,
                      out_res_reg.empty_flag,
                      out_res_reg.full_flag,
                      out_res_reg.reg_write,
                      out_res_reg.commit_dest,
                      out_res_reg.commit_value,
                      out_res_reg.commit_id,
                      out_res_reg.commit_valid,
                      out_res_reg.redirect_pc,
                      out_res_reg.redirect,
                      out_res_reg.write_error,
                      out_res_reg.alloc_id,
                      out_res_reg.alloc_ok};

endmodule

FILE: tb/sv/tb_reorder_buffer_with_branch_recovery_top.sv
// Self-checking stream testbench for the reorder buffer with branch recovery.
`timescale 1ns / 1ps

module tb_reorder_buffer_with_branch_recovery_top;

    localparam int DEPTH = rob_pkg::ROB_DEPTH_DEFAULT;

    // Fourth request code: no operation, only the flags come back
    localparam logic [rob_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

    // Two copies of the buffer state: one steers stimulus, one checks results
    localparam int STIM_VIEW  = 0;
    localparam int CHECK_VIEW = 1;

    localparam int RANDOM_REQS = 1526;
    localparam int HOLD_AT     = 500;   // results seen before the long output stall
    localparam int LONG_HOLD   = 400;   // cycles of that stall
    localparam int DRAIN_AT    = 1000;  // request count at which the sender waits for all results

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    // Buffer state per view
    logic                       busy_m   [2][DEPTH];
    logic                       done_m   [2][DEPTH];
    logic                       branch_m [2][DEPTH];
    logic                       taken_m  [2][DEPTH];
    logic                       guess_m  [2][DEPTH];
    logic [rob_pkg::DEST_W-1:0] dest_m   [2][DEPTH];
    logic [rob_pkg::WORD_W-1:0] value_m  [2][DEPTH];
    logic [rob_pkg::WORD_W-1:0] alt_pc_m [2][DEPTH];
    int unsigned                head_m   [2];
    int unsigned                tail_m   [2];
    int unsigned                fill_m   [2];

    rob_pkg::item_t   pending_q[$];
    rob_pkg::result_t predicted_results[$];
    int unsigned mismatch_cnt = 0;
    int unsigned sent_cnt     = 0;
    int unsigned res_seen     = 0;
    int unsigned send_wait    = 0;
    int unsigned recv_wait    = 0;
    int unsigned hold_left    = 0;
    logic        long_hold    = 1'b0;
    logic        hold_used    = 1'b0;

    reorder_buffer_with_branch_recovery_top #(
        .ROB_DEPTH(DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Empty buffer, pointers at zero
    function automatic void rob_clear(int c);
        for (int k = 0; k < DEPTH; k++)
        begin
            busy_m[c][k]   = 1'b0;
            done_m[c][k]   = 1'b0;
            branch_m[c][k] = 1'b0;
            taken_m[c][k]  = 1'b0;
            guess_m[c][k]  = 1'b0;
            dest_m[c][k]   = '0;
            value_m[c][k]  = '0;
            alt_pc_m[c][k] = '0;
        end
        head_m[c] = 0;
        tail_m[c] = 0;
        fill_m[c] = 0;
    endfunction

    // Apply one request to view c and return the result it must produce
    function automatic rob_pkg::result_t rob_predict(int c, rob_pkg::item_t it);
        rob_pkg::result_t r;
        int unsigned      h;
        int unsigned      t;
        int unsigned      id;
        r = '0;
        if (it.kind == rob_pkg::KIND_ALLOC)
        begin
            if (fill_m[c] < DEPTH)
            begin
                t = tail_m[c];
                busy_m[c][t]   = 1'b1;
                done_m[c][t]   = 1'b0;
                dest_m[c][t]   = it.dest_reg;
                value_m[c][t]  = '0;
                branch_m[c][t] = it.branch_flag;
                taken_m[c][t]  = it.taken_flag;
                guess_m[c][t]  = it.predicted_flag;
                alt_pc_m[c][t] = it.predicted_target;
                r.alloc_ok = 1'b1;
                r.alloc_id = rob_pkg::ID_W'(t);
                tail_m[c]  = (t + 1) % DEPTH;
                fill_m[c]++;
            end
        end
        else if (it.kind == rob_pkg::KIND_WRITE)
        begin
            id = it.target_id;
            if (id >= DEPTH || !busy_m[c][id])
                r.write_error = 1'b1;
            else
            begin
                value_m[c][id] = it.result_value;
                done_m[c][id]  = 1'b1;
            end
        end
        else if (it.kind == rob_pkg::KIND_CYCLE)
        begin
            h = head_m[c];
            // mispredicted branch at the head: flush everything
            if (fill_m[c] != 0 && branch_m[c][h] && done_m[c][h]
                && taken_m[c][h] != guess_m[c][h])
            begin
                r.redirect    = 1'b1;
                r.redirect_pc = taken_m[c][h] ? value_m[c][h] : alt_pc_m[c][h];
                for (int k = 0; k < DEPTH; k++)
                    busy_m[c][k] = 1'b0;
                head_m[c] = tail_m[c];
                fill_m[c] = 0;
            end
            else if (fill_m[c] != 0 && done_m[c][h])
            begin
                busy_m[c][h]   = 1'b0;
                done_m[c][h]   = 1'b0;
                r.commit_valid = 1'b1;
                r.commit_id    = rob_pkg::ID_W'(h);
                r.commit_value = value_m[c][h];
                r.commit_dest  = dest_m[c][h];
                r.reg_write    = (dest_m[c][h] != 0);
                head_m[c] = (h + 1) % DEPTH;
                fill_m[c]--;
            end
        end
        r.full_flag  = (fill_m[c] >= DEPTH);
        r.empty_flag = (fill_m[c] == 0);
        return r;
    endfunction

    // Queue one request and advance the stimulus view
    task automatic add_req(logic [rob_pkg::KIND_W-1:0] kind,
                           logic [rob_pkg::DEST_W-1:0] dest, logic br,
                           logic tk, logic pr, logic [rob_pkg::WORD_W-1:0] pc,
                           logic [rob_pkg::TID_W-1:0] tid,
                           logic [rob_pkg::WORD_W-1:0] val);
        rob_pkg::item_t it;
        it.kind             = kind;
        it.dest_reg         = dest;
        it.branch_flag      = br;
        it.taken_flag       = tk;
        it.predicted_flag   = pr;
        it.predicted_target = pc;
        it.target_id        = tid;
        it.result_value     = val;
        void'(rob_predict(STIM_VIEW, it));
        pending_q.push_back(it);
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch at %0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task automatic compare_result(rob_pkg::result_t want, rob_pkg::result_t got,
                                  logic [1:0] pad);
        if (got.alloc_ok !== want.alloc_ok)
            report_mismatch("alloc_ok", want.alloc_ok, got.alloc_ok);
        if (got.alloc_id !== want.alloc_id)
            report_mismatch("alloc_id", want.alloc_id, got.alloc_id);
        if (got.write_error !== want.write_error)
            report_mismatch("write_error", want.write_error, got.write_error);
        if (got.redirect !== want.redirect)
            report_mismatch("redirect", want.redirect, got.redirect);
        if (got.redirect_pc !== want.redirect_pc)
            report_mismatch("redirect_pc", want.redirect_pc, got.redirect_pc);
        if (got.commit_valid !== want.commit_valid)
            report_mismatch("commit_valid", want.commit_valid, got.commit_valid);
        if (got.commit_id !== want.commit_id)
            report_mismatch("commit_id", want.commit_id, got.commit_id);
        if (got.commit_value !== want.commit_value)
            report_mismatch("commit_value", want.commit_value, got.commit_value);
        if (got.commit_dest !== want.commit_dest)
            report_mismatch("commit_dest", want.commit_dest, got.commit_dest);
        if (got.reg_write !== want.reg_write)
            report_mismatch("reg_write", want.reg_write, got.reg_write);
        if (got.full_flag !== want.full_flag)
            report_mismatch("full_flag", want.full_flag, got.full_flag);
        if (got.empty_flag !== want.empty_flag)
            report_mismatch("empty_flag", want.empty_flag, got.empty_flag);
        if (pad !== 2'b00)
            report_mismatch("padding", 0, pad);
    endtask

    // Driver: one request per handshake, random gap after each in some stretches, none in others
    always @(posedge clk or negedge rst_n)
    begin : driver
        rob_pkg::item_t nxt;
        int unsigned    g;
        int unsigned    n;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            send_wait <= 0;
            sent_cnt  <= 0;
        end
        else
        begin
            g = send_wait;
            n = sent_cnt + ((s_tvalid && s_tready) ? 1 : 0);
            sent_cnt <= n;
            if (!s_tvalid || s_tready)
            begin
                if (g != 0)
                begin
                    g = g - 1;
                    s_tvalid <= 1'b0;
                end
                // at DRAIN_AT the sender waits until every result is back
                else if (pending_q.size() != 0 && !(n == DRAIN_AT && res_seen < n))
                begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.result_value, nxt.target_id, nxt.predicted_target,
                                 nxt.predicted_flag, nxt.taken_flag, nxt.branch_flag,
                                 nxt.dest_reg};
                    s_tuser  <= nxt.kind;
                    g = ((n / 128) % 3 == 0) ? 0 : $urandom_range(0, 4);
                end
                else
                    s_tvalid <= 1'b0;
            end
            send_wait <= g;
        end
    end

    // Monitor: predicts on each accepted request, checks each accepted result
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rob_pkg::item_t   req;
        rob_pkg::result_t got;
        int unsigned      w;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
            res_seen  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                req.kind             = s_tuser;
                req.dest_reg         = s_tdata[4:0];
                req.branch_flag      = s_tdata[5];
                req.taken_flag       = s_tdata[6];
                req.predicted_flag   = s_tdata[7];
                req.predicted_target = s_tdata[39:8];
                req.target_id        = s_tdata[47:40];
                req.result_value     = s_tdata[79:48];
                predicted_results.push_back(rob_predict(CHECK_VIEW, req));
            end
            w = recv_wait;
            if (m_tvalid && m_tready)
            begin
                got.alloc_ok     = m_tdata[0];
                got.alloc_id     = m_tdata[5:1];
                got.write_error  = m_tdata[6];
                got.redirect     = m_tdata[7];
                got.redirect_pc  = m_tdata[39:8];
                got.commit_valid = m_tdata[40];
                got.commit_id    = m_tdata[45:41];
                got.commit_value = m_tdata[77:46];
                got.commit_dest  = m_tdata[82:78];
                got.reg_write    = m_tdata[83];
                got.full_flag    = m_tdata[84];
                got.empty_flag   = m_tdata[85];
                if (predicted_results.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result 0x%0h at %0t ns", m_tdata, $time);
                end
                else
                    compare_result(predicted_results.pop_front(), got, m_tdata[87:86]);
                res_seen <= res_seen + 1;
                w = ((res_seen / 100) % 3 == 1) ? 0 : $urandom_range(0, 4);
            end
            else if (w != 0)
                w = w - 1;
            recv_wait <= w;
            m_tready  <= (w == 0) && !long_hold;
        end
    end

    // One long output stall so the block backs up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin : long_stall
        if (!rst_n)
        begin
            long_hold <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (!hold_used && res_seen >= HOLD_AT)
        begin
            long_hold <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            long_hold <= (hold_left != 1);
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : main
        int unsigned phase;
        int unsigned roll;
        int unsigned off;
        int unsigned miss_odds;
        logic        br;
        logic        tk;
        rob_clear(STIM_VIEW);
        rob_clear(CHECK_VIEW);

        // directed: empty cycle, bad writes, no-op, commits, both redirect flavors
        add_req(rob_pkg::KIND_CYCLE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h1);
        add_req(KIND_NONE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_ALLOC, 5'd0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_ALLOC, 5'd31, 1'b1, 1'b1, 1'b1, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_CYCLE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd255, 32'h5);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd32, 32'h6);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd1, 32'hFFFF_FFFF);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'hA5A5_5A5A);
        add_req(rob_pkg::KIND_CYCLE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_CYCLE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_CYCLE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_ALLOC, 5'd7, 1'b1, 1'b1, 1'b0, 32'h1234_5678, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_ALLOC, 5'd3, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd3, 32'h0000_0042);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd2, 32'hDEAD_BEEF);
        add_req(rob_pkg::KIND_CYCLE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd3, 32'h7);
        add_req(rob_pkg::KIND_ALLOC, 5'd0, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'd0, 32'h0);
        add_req(rob_pkg::KIND_WRITE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd4, 32'h0);
        add_req(rob_pkg::KIND_CYCLE, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 8'd0, 32'h0);
        add_req(KIND_NONE, 5'd31, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);

        // random: phases that fill, drain or mix, with a little noise
        phase = 2;
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i % 64 == 0)
                phase = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                if (roll < 3)
                    add_req(KIND_NONE, 5'($urandom), 1'($urandom), 1'($urandom),
                            1'($urandom), $urandom, 8'($urandom), $urandom);
                else
                    add_req(rob_pkg::KIND_WRITE, 5'($urandom), 1'($urandom),
                            1'($urandom), 1'($urandom), $urandom,
                            8'($urandom_range(0, 255)), $urandom);
                continue;
            end
            roll = $urandom_range(0, 99);
            if ((phase == 0 && roll < 65) || (phase == 1 && roll < 10)
                || (phase == 2 && roll < 35))
            begin
                // fill phases rarely mispredict so the buffer can run full
                miss_odds = (phase == 0) ? 15 : 3;
                br = ($urandom_range(0, 2) == 0);
                tk = 1'($urandom);
                add_req(rob_pkg::KIND_ALLOC, 5'($urandom), br, tk,
                        ($urandom_range(0, miss_odds) == 0) ? !tk : tk,
                        $urandom, 8'($urandom), $urandom);
            end
            else if ((phase == 0 && roll < 85) || (phase == 1 && roll < 55)
                     || (phase == 2 && roll < 70))
            begin
                // write mostly to the head so entries retire
                if (fill_m[STIM_VIEW] == 0)
                    off = $urandom_range(0, DEPTH - 1);
                else if ($urandom_range(0, 9) < 6)
                    off = 0;
                else
                    off = $urandom_range(0, fill_m[STIM_VIEW] - 1);
                add_req(rob_pkg::KIND_WRITE, 5'($urandom), 1'($urandom), 1'($urandom),
                        1'($urandom), $urandom,
                        8'((head_m[STIM_VIEW] + off) % DEPTH), $urandom);
            end
            else
                add_req(rob_pkg::KIND_CYCLE, 5'($urandom), 1'($urandom), 1'($urandom),
                        1'($urandom), $urandom, 8'($urandom), $urandom);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (!(pending_q.size() == 0 && !s_tvalid && predicted_results.size() == 0));
        repeat (8) @(negedge clk);

        if (mismatch_cnt == 0)
            $display("** reorder_buffer_with_branch_recovery_top: PASSED **");
        else
            $display("** reorder_buffer_with_branch_recovery_top: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("** reorder_buffer_with_branch_recovery_top: FAILED **");
        $finish;
    end

endmodule
